[rtl/assert_macros.svh]
// Assertion macros shared by the RTL; they compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property checked on every rising clock edge out of reset
`define CHK_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// Condition that must never be true out of reset
`define CHK_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define CHK_PROP(lbl, clk, rst_n, prop)
`define CHK_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/sdulpd_pkg.sv]
// Constants for the length-prefix deframer.
package sdulpd_pkg;

    // Bytes held while probing the first packet (4 to 8)
    localparam int PROBE_LEN = 5;

    // Probe count width (holds PROBE_LEN itself) and store index width
    localparam int CNT_W = $clog2(PROBE_LEN + 1);
    localparam int IDX_W = $clog2(PROBE_LEN);

    // Probe signature: held byte 2 in KIND_MIN..KIND_MAX, held byte 3 equal to VER_VAL
    localparam int KIND_IDX = 2;
    localparam int VER_IDX  = 3;
    localparam logic [7:0] KIND_MIN = 8'd20;
    localparam logic [7:0] KIND_MAX = 8'd23;
    localparam logic [7:0] VER_VAL  = 8'd3;

    // Header phase codes
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

endpackage

[rtl/sdu_length_prefix_deframer.sv]
// Length-prefix deframer: probes the first packet, then strips headers or passes bytes.
// A byte in decided mode that yields a result has it in the output register in the next cycle.
// Throughput: one byte per cycle once the mode is decided; the input waits only while the
// probe store is replayed or the output register holds a result that the result side has not taken.
// The byte that ends probing stalls the input while the probe store, that byte included, is
// replayed one byte per cycle, while the output register is free, through the header/payload path.
// Reset: synchronous active-low aresetn clears all control state; probe store is not reset.
`include "assert_macros.svh"

module sdu_length_prefix_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // packet_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // end_of_sdu
    output logic       m_tlast    // last_of_run
);

    localparam int CW = sdulpd_pkg::CNT_W;
    localparam int IW = sdulpd_pkg::IDX_W;

    // Probe and mode state
    logic [7:0]    store_reg [sdulpd_pkg::PROBE_LEN];
    logic [CW-1:0] probe_count_reg, probe_count_next;
    logic          mode_decided_reg, mode_decided_next;
    logic          strip_mode_reg, strip_mode_next;

    // Header parser state
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  header_low_reg, header_low_next;
    logic [15:0] bytes_left_reg, bytes_left_next;

    // Replay sequencer
    logic          replay_active_reg, replay_active_next;
    logic [CW-1:0] replay_idx_reg, replay_idx_next;
    logic [CW-1:0] replay_cnt_reg, replay_cnt_next;

    // Held result during replay, so the final one can carry last_of_run
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg, hold_byte_next;
    logic       hold_eos_reg, hold_eos_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_eos_reg, out_eos_next;
    logic       out_last_reg, out_last_next;

    // Handshake and step control
    logic          out_free, in_fire, step_go;
    logic          replay_route, replay_flush, live_route, route_en;
    logic [7:0]    route_byte;
    logic [CW-1:0] cnt_inc;
    logic          probe_full, decide, strip_hit;
    logic [7:0]    key_kind, key_ver;

    // Route outputs
    logic        res_valid, res_eos;
    logic [1:0]  rt_phase;
    logic [7:0]  rt_header_low;
    logic [15:0] rt_bytes_left;
    logic [15:0] hdr_len;

    assign out_free     = !m_valid_reg || m_tready;
    assign s_tready     = !replay_active_reg && out_free;
    assign in_fire      = s_tvalid && s_tready;
    assign step_go      = replay_active_reg && out_free;
    assign replay_route = step_go && (replay_idx_reg != replay_cnt_reg);
    assign replay_flush = step_go && (replay_idx_reg == replay_cnt_reg);
    assign live_route   = in_fire && mode_decided_reg;
    assign route_en     = replay_route || live_route;
    assign route_byte   = replay_active_reg ? store_reg[replay_idx_reg[IW-1:0]] : s_tdata;

    // Probe decision; the incoming byte is forwarded in if it lands on a key slot
    assign cnt_inc    = probe_count_reg + CW'(1);
    assign probe_full = (cnt_inc == CW'(sdulpd_pkg::PROBE_LEN));
    assign decide     = probe_full || s_tlast;
    assign key_kind   = (probe_count_reg == CW'(sdulpd_pkg::KIND_IDX)) ? s_tdata :
                        store_reg[sdulpd_pkg::KIND_IDX];
    assign key_ver    = (probe_count_reg == CW'(sdulpd_pkg::VER_IDX)) ? s_tdata :
                        store_reg[sdulpd_pkg::VER_IDX];
    assign strip_hit  = probe_full && (key_kind >= sdulpd_pkg::KIND_MIN) &&
                        (key_kind <= sdulpd_pkg::KIND_MAX) && (key_ver == sdulpd_pkg::VER_VAL);

    // Header/payload routing of one byte
    assign hdr_len = {route_byte, header_low_reg};

    always_comb begin
        res_valid     = 1'b0;
        res_eos       = 1'b0;
        rt_phase      = phase_reg;
        rt_header_low = header_low_reg;
        rt_bytes_left = bytes_left_reg;
        if (!strip_mode_reg) begin
            res_valid = 1'b1;
        end else begin
            unique case (phase_reg)
                sdulpd_pkg::PH_HIGH: begin
                    rt_bytes_left = hdr_len;
                    rt_phase      = (hdr_len == 16'd0) ? sdulpd_pkg::PH_LOW : sdulpd_pkg::PH_DATA;
                end
                sdulpd_pkg::PH_DATA: begin
                    rt_bytes_left = bytes_left_reg - 16'd1;
                    res_valid     = 1'b1;
                    res_eos       = (bytes_left_reg == 16'd1);
                    rt_phase      = res_eos ? sdulpd_pkg::PH_LOW : sdulpd_pkg::PH_DATA;
                end
                default: begin
                    // awaiting low header byte; the unused code behaves the same
                    rt_header_low = route_byte;
                    rt_phase      = sdulpd_pkg::PH_HIGH;
                end
            endcase
        end
    end

    // Next-state logic
    always_comb begin
        probe_count_next   = probe_count_reg;
        mode_decided_next  = mode_decided_reg;
        strip_mode_next    = strip_mode_reg;
        phase_next         = phase_reg;
        header_low_next    = header_low_reg;
        bytes_left_next    = bytes_left_reg;
        replay_active_next = replay_active_reg;
        replay_idx_next    = replay_idx_reg;
        replay_cnt_next    = replay_cnt_reg;
        hold_valid_next    = hold_valid_reg;
        hold_byte_next     = hold_byte_reg;
        hold_eos_next      = hold_eos_reg;
        m_valid_next       = m_valid_reg;
        out_byte_next      = out_byte_reg;
        out_eos_next       = out_eos_reg;
        out_last_next      = out_last_reg;

        if (out_free) begin
            m_valid_next = 1'b0;
        end

        // Probing: hold the byte, decide the mode on a full store or packet end
        if (in_fire && !mode_decided_reg) begin
            if (decide) begin
                mode_decided_next  = 1'b1;
                strip_mode_next    = strip_hit;
                probe_count_next   = '0;
                replay_active_next = 1'b1;
                replay_idx_next    = '0;
                replay_cnt_next    = cnt_inc;
            end else begin
                probe_count_next = cnt_inc;
            end
        end

        if (route_en) begin
            phase_next      = rt_phase;
            header_low_next = rt_header_low;
            bytes_left_next = rt_bytes_left;
        end

        // Live byte: its result is the whole run
        if (live_route && res_valid) begin
            m_valid_next  = 1'b1;
            out_byte_next = route_byte;
            out_eos_next  = res_eos;
            out_last_next = 1'b1;
        end

        // Replay step: push the held result out, hold the new one
        if (replay_route) begin
            replay_idx_next = replay_idx_reg + CW'(1);
            if (res_valid) begin
                if (hold_valid_reg) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = hold_byte_reg;
                    out_eos_next  = hold_eos_reg;
                    out_last_next = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_byte_next  = route_byte;
                hold_eos_next   = res_eos;
            end
        end

        // Replay end: the held result closes the run
        if (replay_flush) begin
            replay_active_next = 1'b0;
            hold_valid_next    = 1'b0;
            if (hold_valid_reg) begin
                m_valid_next  = 1'b1;
                out_byte_next = hold_byte_reg;
                out_eos_next  = hold_eos_reg;
                out_last_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_count_reg   <= '0;
            mode_decided_reg  <= 1'b0;
            strip_mode_reg    <= 1'b0;
            phase_reg         <= sdulpd_pkg::PH_LOW;
            header_low_reg    <= '0;
            bytes_left_reg    <= '0;
            replay_active_reg <= 1'b0;
            replay_idx_reg    <= '0;
            replay_cnt_reg    <= '0;
            hold_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            probe_count_reg   <= probe_count_next;
            mode_decided_reg  <= mode_decided_next;
            strip_mode_reg    <= strip_mode_next;
            phase_reg         <= phase_next;
            header_low_reg    <= header_low_next;
            bytes_left_reg    <= bytes_left_next;
            replay_active_reg <= replay_active_next;
            replay_idx_reg    <= replay_idx_next;
            replay_cnt_reg    <= replay_cnt_next;
            hold_valid_reg    <= hold_valid_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire && !mode_decided_reg) begin
            store_reg[probe_count_reg[IW-1:0]] <= s_tdata;
        end
        hold_byte_reg <= hold_byte_next;
        hold_eos_reg  <= hold_eos_next;
        out_byte_reg  <= out_byte_next;
        out_eos_reg   <= out_eos_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_eos_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `CHK_NEVER(a_no_req_in_replay, aclk, aresetn, replay_active_reg && s_tready)
    `CHK_PROP(a_hold_in_replay, aclk, aresetn, hold_valid_reg |-> replay_active_reg)
    `CHK_PROP(a_pass_no_eos, aclk, aresetn, (m_valid_reg && !strip_mode_reg) |-> !out_eos_reg)
    `CHK_PROP(a_count_cleared, aclk, aresetn, mode_decided_reg |-> (probe_count_reg == '0))

endmodule
